### rtl/cqf_pkg.sv
`default_nettype none

package cqf_pkg;

    // Field widths fixed by the interface
    localparam int DATA_W   = 32;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;
    localparam int CAP_W    = 5;

    // Capacity register value after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef logic signed [DATA_W-1:0] data_t;

    // Request kinds; the fourth code is ignored
    typedef enum logic [REQ_W-1:0] {
        REQ_ENQ  = 2'd0,
        REQ_DEQ  = 2'd1,
        REQ_DUMP = 2'd2
    } req_kind_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2,
        STAT_EMPTY     = 2'd3
    } status_t;

    // Control sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_RESP
    } state_t;

endpackage

`default_nettype wire

### rtl/cqf_req_if.sv
`default_nettype none

interface cqf_req_if;
    logic                         valid;
    logic                         ready;
    logic [cqf_pkg::REQ_W-1:0]    req_type;
    cqf_pkg::data_t               value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

`default_nettype wire

### rtl/cqf_res_if.sv
`default_nettype none

interface cqf_res_if;
    logic                valid;
    logic                ready;
    cqf_pkg::status_t    status;
    cqf_pkg::data_t      data;
    logic                last;

    modport source (output valid, output status, output data, output last, input ready);
    modport sink   (input valid, input status, input data, input last, output ready);
endinterface

`default_nettype wire

### rtl/cqf_ram.sv
`default_nettype none

module cqf_ram #(
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic            clk,
    input  wire logic            wr_en,
    input  wire logic [AW-1:0]   wr_addr,
    input  wire cqf_pkg::data_t  wr_data,
    input  wire logic            rd_en,
    input  wire logic [AW-1:0]   rd_addr,
    output cqf_pkg::data_t       rd_data
);
    import cqf_pkg::*;

    data_t mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/circular_queue_fifo_core.sv
// Enqueue, overflow, underflow and empty-dump: result loaded into the output register as the
// item is taken, or held until that register frees up; next item taken the following cycle
// while the output is free. Dequeue: entry passes the RAM read register, then the output
// register; no new item is taken meanwhile. Dump of N entries: first entry on the same path,
// then one per cycle while the output is free, bound by the single RAM read port. Async
// active-low reset empties the queue and sets capacity to 16; slot contents are not cleared.
`default_nettype none

module circular_queue_fifo_core #(
    parameter int DEPTH = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_wr_en,
    input  wire logic [cqf_pkg::CAP_W-1:0] cfg_wr_data,
    cqf_req_if.sink                        req,
    cqf_res_if.source                      res
);
    import cqf_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW = ((IW > CAP_W) ? IW : CAP_W) + 1;

    typedef logic [IW-1:0] idx_t;
    typedef logic [XW-1:0] ext_t;

    // Next index around the ring, wrapping at the capacity in use
    function automatic idx_t ring_adv(input idx_t idx, input ext_t cap);
        ext_t n;
        n = ext_t'(idx) + ext_t'(1);
        return (n >= cap) ? '0 : n[IW-1:0];
    endfunction

    state_t              state_reg, state_next;
    idx_t                head_reg, head_next;
    idx_t                tail_reg, tail_next;
    logic                empty_reg, empty_next;
    logic [CAP_W-1:0]    cap_reg;
    idx_t                walk_idx_reg, walk_idx_next;
    logic [CAP_W-1:0]    walk_cnt_reg, walk_cnt_next;
    logic                walk_last_reg, walk_last_next;
    status_t             resp_status_reg, resp_status_next;
    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    data_t               out_data_reg, out_data_next;
    logic                out_last_reg, out_last_next;

    logic                ram_wr_en;
    idx_t                ram_wr_addr;
    logic                ram_rd_en;
    idx_t                ram_rd_addr;
    data_t               ram_rd_data;

    ext_t                cap_use;
    logic                req_acc;
    logic                out_free;
    logic                is_full;
    idx_t                tail_adv;
    idx_t                head_adv;
    idx_t                walk_adv;
    logic [CAP_W-1:0]    walk_cnt_inc;
    logic                acc_read;
    logic                acc_emit;
    logic                emit;
    status_t             emit_status;
    data_t               emit_data;
    logic                emit_last;

    cqf_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (req.value),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Clamp capacity to 1..DEPTH
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_use = ext_t'(1);
        end
        else if (ext_t'(cap_reg) > ext_t'(DEPTH))
        begin
            cap_use = ext_t'(DEPTH);
        end
        else
        begin
            cap_use = ext_t'(cap_reg);
        end
    end

    assign req_acc      = req.valid && req.ready;
    assign out_free     = !out_valid_reg || res.ready;
    assign tail_adv     = ring_adv(tail_reg, cap_use);
    assign head_adv     = ring_adv(head_reg, cap_use);
    assign walk_adv     = ring_adv(walk_idx_reg, cap_use);
    assign walk_cnt_inc = walk_cnt_reg + CAP_W'(1);
    assign is_full      = !empty_reg && (tail_adv == head_reg);

    // Classify the taken item: RAM read needed, or an immediate result
    assign acc_read = req_acc && !empty_reg &&
                      ((req.req_type == REQ_DEQ) || (req.req_type == REQ_DUMP));
    assign acc_emit = req_acc && ((req.req_type == REQ_ENQ) ||
                      (empty_reg && ((req.req_type == REQ_DEQ) ||
                                     (req.req_type == REQ_DUMP))));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (acc_read)
                begin
                    state_next = S_READ;
                end
                else if (acc_emit && !out_free)
                begin
                    state_next = S_RESP;
                end
            end
            S_READ:
            begin
                if (out_free && walk_last_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Queue update, RAM access and result emission
    always_comb
    begin
        head_next        = head_reg;
        tail_next        = tail_reg;
        empty_next       = empty_reg;
        walk_idx_next    = walk_idx_reg;
        walk_cnt_next    = walk_cnt_reg;
        walk_last_next   = walk_last_reg;
        resp_status_next = resp_status_reg;
        out_valid_next   = out_valid_reg && !res.ready;
        out_status_next  = out_status_reg;
        out_data_next    = out_data_reg;
        out_last_next    = out_last_reg;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = empty_reg ? '0 : tail_adv;
        ram_rd_en        = 1'b0;
        ram_rd_addr      = head_reg;
        emit             = 1'b0;
        emit_status      = STAT_OK;
        emit_data        = '0;
        emit_last        = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (req_acc)
                begin
                    case (req.req_type)
                        REQ_ENQ:
                        begin
                            emit = 1'b1;
                            if (is_full)
                            begin
                                emit_status = STAT_OVERFLOW;
                            end
                            else
                            begin
                                ram_wr_en  = 1'b1;
                                tail_next  = ram_wr_addr;
                                empty_next = 1'b0;
                                if (empty_reg)
                                begin
                                    head_next = '0;
                                end
                            end
                        end
                        REQ_DEQ:
                        begin
                            if (empty_reg)
                            begin
                                emit        = 1'b1;
                                emit_status = STAT_UNDERFLOW;
                            end
                            else
                            begin
                                ram_rd_en      = 1'b1;
                                walk_last_next = 1'b1;
                                if (head_reg == tail_reg)
                                begin
                                    head_next  = '0;
                                    tail_next  = '0;
                                    empty_next = 1'b1;
                                end
                                else
                                begin
                                    head_next = head_adv;
                                end
                            end
                        end
                        REQ_DUMP:
                        begin
                            if (empty_reg)
                            begin
                                emit        = 1'b1;
                                emit_status = STAT_EMPTY;
                            end
                            else
                            begin
                                ram_rd_en      = 1'b1;
                                walk_idx_next  = head_reg;
                                walk_cnt_next  = CAP_W'(1);
                                walk_last_next = (head_reg == tail_reg) ||
                                                 (cap_use <= ext_t'(1));
                            end
                        end
                        default:
                        begin
                            // drop unknown request kinds
                        end
                    endcase
                end
            end
            S_READ:
            begin
                // emit the entry the RAM has read and, unless it is the last, fetch the next one
                if (out_free)
                begin
                    emit      = 1'b1;
                    emit_data = ram_rd_data;
                    emit_last = walk_last_reg;
                    if (!walk_last_reg)
                    begin
                        ram_rd_en      = 1'b1;
                        ram_rd_addr    = walk_adv;
                        walk_idx_next  = walk_adv;
                        walk_cnt_next  = walk_cnt_inc;
                        walk_last_next = (walk_adv == tail_reg) ||
                                         (ext_t'(walk_cnt_inc) >= cap_use);
                    end
                end
            end
            S_RESP:
            begin
                emit        = 1'b1;
                emit_status = resp_status_reg;
            end
            default:
            begin
            end
        endcase

        // Load the output register, or hold the status until it frees up
        if (emit)
        begin
            if (out_free)
            begin
                out_valid_next  = 1'b1;
                out_status_next = emit_status;
                out_data_next   = emit_data;
                out_last_next   = emit_last;
            end
            else
            begin
                resp_status_next = emit_status;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            empty_reg     <= 1'b1;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            empty_reg     <= empty_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    // Payload and walk registers
    always_ff @(posedge clk)
    begin
        walk_idx_reg    <= walk_idx_next;
        walk_cnt_reg    <= walk_cnt_next;
        walk_last_reg   <= walk_last_next;
        resp_status_reg <= resp_status_next;
        out_status_reg  <= out_status_next;
        out_data_reg    <= out_data_next;
        out_last_reg    <= out_last_next;
    end

    assign req.ready  = (state_reg == S_IDLE);
    assign res.valid  = out_valid_reg;
    assign res.status = out_status_reg;
    assign res.data   = out_data_reg;
    assign res.last   = out_last_reg;

endmodule

`default_nettype wire

### rtl/cqf_checker.sv
`default_nettype none

module cqf_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          req_valid,
    input wire logic                          req_ready,
    input wire logic [cqf_pkg::REQ_W-1:0]     req_type,
    input wire logic                          res_valid,
    input wire logic                          res_ready,
    input wire logic [cqf_pkg::STATUS_W-1:0]  res_status,
    input wire logic [cqf_pkg::DATA_W-1:0]    res_data,
    input wire logic                          res_last
);
    import cqf_pkg::*;

    // Stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_status) &&
        $stable(res_data) && $stable(res_last))
        else $error("result changed while stalled");

    // Error and empty results are single, zero-data items
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_status != STAT_OK) |-> res_last && (res_data == '0))
        else $error("error result not last or data nonzero");

    // A taken dequeue leaves the queue busy or a result valid in the next cycle
    a_deq_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_type == REQ_DEQ) |=> !req_ready || res_valid)
        else $error("dequeue neither busy nor answered");

    // While a dump is still emitting, no new item is taken
    a_dump_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_last |-> !req_ready)
        else $error("item taken during dump");

endmodule

bind circular_queue_fifo_core cqf_checker u_cqf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .req_type   (req.req_type),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .res_status (res.status),
    .res_data   (res.data),
    .res_last   (res.last)
);

`default_nettype wire
